FILE: src/ltms_pkg.sv
package ltms_pkg;

	// widths fixed by the port definition
	localparam int MODE_W     = 3;
	localparam int SEL_W      = 4;
	localparam int POS_W      = 13;
	localparam int TV_W       = 8;
	localparam int TILE_OUT_W = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;
	localparam int CFG_LAYERS = 4;

	typedef enum logic [MODE_W-1:0] {
		MODE_READ  = 3'd0,
		MODE_WRITE = 3'd1,
		MODE_MARK  = 3'd2,
		MODE_QUERY = 3'd3,
		MODE_TEST  = 3'd4
	} mode_t;

	typedef struct packed {
		logic en;
		logic we;
	} ram_ctl_t;

endpackage

FILE: src/ltms_ram.sv
module ltms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

FILE: src/ltms_cfg.sv
module ltms_cfg
	import ltms_pkg::*;
#(
	parameter int NUM_LAYERS = 4,
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int DIM_W      = 7
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [CFG_IDX_W-1:0]                cfg_idx,
	input  logic [CFG_DATA_W-1:0]               cfg_data,
	output logic [NUM_LAYERS-1:0][DIM_W-1:0]    layer_w,
	output logic [NUM_LAYERS-1:0][DIM_W-1:0]    layer_h
);

	localparam int REG_LAYERS = (NUM_LAYERS < CFG_LAYERS) ? NUM_LAYERS : CFG_LAYERS;

	logic [DIM_W-1:0] w_q [REG_LAYERS];
	logic [DIM_W-1:0] h_q [REG_LAYERS];
	logic [DIM_W-1:0] w_new;
	logic [DIM_W-1:0] h_new;

	// oversized dimensions saturate at the maximum
	assign w_new = (int'(cfg_data) > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : DIM_W'(cfg_data);
	assign h_new = (int'(cfg_data) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : DIM_W'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < REG_LAYERS; l++) begin
				w_q[l] <= '0;
				h_q[l] <= '0;
			end
		end else if (cfg_we) begin
			for (int l = 0; l < REG_LAYERS; l++) begin
				if (int'(cfg_idx[CFG_IDX_W-1:1]) == l) begin
					if (!cfg_idx[0]) begin
						w_q[l] <= w_new;
					end else begin
						h_q[l] <= h_new;
					end
				end
			end
		end
	end

	for (genvar l = 0; l < NUM_LAYERS; l++) begin : g_dim
		if (l < REG_LAYERS) begin : g_reg
			assign layer_w[l] = w_q[l];
			assign layer_h[l] = h_q[l];
		end else begin : g_absent
			assign layer_w[l] = '0;
			assign layer_h[l] = '0;
		end
	end

endmodule

FILE: src/ltms_seq.sv
module ltms_seq
	import ltms_pkg::*;
#(
	parameter int NUM_LAYERS   = 4,
	parameter int MAX_WIDTH    = 64,
	parameter int MAX_HEIGHT   = 64,
	parameter int TILE_ID_BITS = 8,
	parameter int DIM_W        = 7,
	parameter int TAW          = 14
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [MODE_W-1:0]                  mode,
	input  logic signed [SEL_W-1:0]            layer_sel,
	input  logic signed [POS_W-1:0]            pos_x,
	input  logic signed [POS_W-1:0]            pos_y,
	input  logic [TV_W-1:0]                    tile_value,
	input  logic [NUM_LAYERS-1:0][DIM_W-1:0]   layer_w,
	input  logic [NUM_LAYERS-1:0][DIM_W-1:0]   layer_h,
	output ram_ctl_t                           tile_ctl,
	output logic [TAW-1:0]                     tile_addr,
	output logic [TILE_ID_BITS-1:0]            tile_wdata,
	input  logic [TILE_ID_BITS-1:0]            tile_rdata,
	output ram_ctl_t                           mark_ctl,
	output logic [TILE_ID_BITS-1:0]            mark_addr,
	input  logic                               mark_rdata,
	output logic                               done,
	output logic signed [TILE_OUT_W-1:0]       tile_out,
	output logic                               is_collision,
	output logic                               rejected
);

	localparam int LAYER_CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int LYW         = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
	localparam int PW          = POS_W + DIM_W + 1;
	localparam int AW          = 2 * DIM_W;
	localparam int MD          = 2 ** TILE_ID_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	state_t                    state_q;
	logic [MODE_W-1:0]         mode_q;
	logic                      sel_ok_q;
	logic [LYW-1:0]            lay_q;
	logic signed [POS_W-1:0]   x_q;
	logic signed [POS_W-1:0]   y_q;
	logic [TILE_ID_BITS-1:0]   tv_q;
	logic                      coll_q;
	logic [MD-1:0]             mark_vld_q;

	logic                      accept;
	logic                      is_rd;
	logic                      is_wr;
	logic                      is_query;
	logic                      issue;
	logic                      last_issue;
	logic [DIM_W-1:0]          w_cur;
	logic [DIM_W-1:0]          h_cur;
	logic signed [PW-1:0]      x_ext;
	logic signed [PW-1:0]      y_ext;
	logic signed [PW-1:0]      w_ext;
	logic signed [PW-1:0]      h_ext;
	logic signed [PW-1:0]      prod;
	logic [AW-1:0]             area;
	logic                      inb;

	// stage 1: product and area registered
	logic                      v_s1;
	logic                      last_s1;
	logic [LYW-1:0]            layer_s1;
	logic signed [PW-1:0]      prod_s1;
	logic [AW-1:0]             area_s1;
	logic                      inb_s1;

	// stage 2: tile memory access issued
	logic signed [PW-1:0]      lin;
	logic                      rw_ok;
	logic                      tile_go;
	logic                      v_s2;
	logic                      last_s2;
	logic                      tok_s2;

	// stage 3: collision mark access issued
	logic                      mark_go;
	logic                      v_s3;
	logic                      last_s3;
	logic                      tok_s3;
	logic                      mok_s3;
	logic [TILE_ID_BITS-1:0]   maddr_s3;
	logic [TILE_ID_BITS-1:0]   tile_s3;

	logic                      hit;
	logic [15:0]               tile_wide;
	logic [15:0]               tv_wide;

	assign accept   = start && !busy;
	assign busy     = (state_q != ST_IDLE);
	assign is_rd    = (mode_q == MODE_READ);
	assign is_wr    = (mode_q == MODE_WRITE);
	assign is_query = (mode_q == MODE_QUERY);

	assign issue      = (state_q == ST_ISSUE);
	assign last_issue = !is_query || (lay_q == LYW'(NUM_LAYERS - 1));

	assign tv_wide = {8'd0, tile_value};

	// issue stage: dimensions of the current layer
	assign w_cur = layer_w[lay_q];
	assign h_cur = layer_h[lay_q];
	assign x_ext = PW'(x_q);
	assign y_ext = PW'(y_q);
	assign w_ext = PW'(w_cur);
	assign h_ext = PW'(h_cur);
	assign prod  = y_ext * w_ext;
	assign area  = w_cur * h_cur;
	assign inb   = !x_q[POS_W-1] && (x_ext < w_ext) && !y_q[POS_W-1] && (y_ext < h_ext);

	always_ff @(posedge clk) begin
		layer_s1 <= lay_q;
		prod_s1  <= prod;
		area_s1  <= area;
		inb_s1   <= inb;
		last_s1  <= last_issue;
	end

	// linear index, checked only against zero and the layer area
	assign lin     = prod_s1 + x_ext;
	assign rw_ok   = sel_ok_q && !lin[PW-1] && (lin < $signed(PW'(area_s1)));
	assign tile_go = ((is_rd || is_wr) && rw_ok) || (is_query && inb_s1);

	assign tile_ctl.en = v_s1 && tile_go;
	assign tile_ctl.we = is_wr;
	assign tile_addr   = TAW'(layer_s1 * LAYER_CELLS) + TAW'(lin);
	assign tile_wdata  = tv_q;

	always_ff @(posedge clk) begin
		last_s2 <= last_s1;
		tok_s2  <= tile_go;
	end

	// mark lookup: the tile just read for a query, the item's id otherwise
	assign mark_go     = is_query ? tok_s2 : ((mode_q == MODE_MARK) || (mode_q == MODE_TEST));
	assign mark_ctl.en = v_s2 && mark_go;
	assign mark_ctl.we = (mode_q == MODE_MARK);
	assign mark_addr   = is_query ? tile_rdata : tv_q;

	always_ff @(posedge clk) begin
		last_s3  <= last_s2;
		tok_s3   <= tok_s2;
		mok_s3   <= mark_go && (mode_q != MODE_MARK);
		maddr_s3 <= mark_addr;
		tile_s3  <= tile_rdata;
	end

	assign hit       = mok_s3 && mark_vld_q[maddr_s3] && mark_rdata;
	assign tile_wide = 16'(tile_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_vld_q <= '0;
		end else if (mark_ctl.en && mark_ctl.we) begin
			mark_vld_q[mark_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			x_q    <= pos_x;
			y_q    <= pos_y;
			tv_q   <= tv_wide[TILE_ID_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			sel_ok_q     <= 1'b0;
			lay_q        <= '0;
			coll_q       <= 1'b0;
			done         <= 1'b0;
			tile_out     <= '1;
			is_collision <= 1'b0;
			rejected     <= 1'b0;
		end else begin
			done <= 1'b0;
			if (v_s3) begin
				coll_q <= coll_q || hit;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						sel_ok_q <= !layer_sel[SEL_W-1] && (int'(layer_sel[2:0]) < NUM_LAYERS);
						coll_q   <= 1'b0;
						if ((mode == MODE_QUERY) || layer_sel[SEL_W-1]
							|| (int'(layer_sel[2:0]) >= NUM_LAYERS)) begin
							lay_q <= '0;
						end else begin
							lay_q <= LYW'(layer_sel[2:0]);
						end
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end else begin
						lay_q <= lay_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (v_s3 && last_s3) begin
						done         <= 1'b1;
						tile_out     <= (is_rd && tok_s3) ? $signed(tile_wide[TILE_OUT_W-1:0])
							: '1;
						is_collision <= ((mode_q == MODE_QUERY) || (mode_q == MODE_TEST))
							&& (coll_q || hit);
						rejected     <= (is_rd || is_wr) && !tok_s3;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// the pipe is empty when a word is shown
	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(v_s1 || v_s2 || v_s3))
		else $error("result shown with passes still in flight");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an item in progress");

	a_tile_write_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(tile_ctl.en && tile_ctl.we) |-> (is_wr && sel_ok_q && busy))
		else $error("tile write outside an accepted write");

	a_mark_write_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(mark_ctl.en && mark_ctl.we) |-> (mode_q == MODE_MARK))
		else $error("collision mark written outside a mark item");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && !done)
		else $error("accepted item did not raise busy");

endmodule

FILE: src/layered_tile_map_store_core.sv
// channel  | ports                                                   | handshake
// ---------+---------------------------------------------------------+----------------------------
// item     | mode, layer_sel, pos_x, pos_y, tile_value               | taken when start && !busy
// result   | tile_out, is_collision, rejected                        | one word per item, on done
// config   | cfg_we, cfg_idx, cfg_data                               | written when cfg_we is high
//
// a collision query runs one pass per layer through the tile memory and then the
// mark memory; every other item makes a single pass through both.
// the tile memory and mark memory are single-port, with one access per pass each.
// busy falls in the cycle done is shown, so the next item can start then.
// arst_n clears the dimensions and the collision marks at once; tile cells are
// undefined until written. done cannot be held off by the receiver.
module layered_tile_map_store_core
	import ltms_pkg::*;
#(
	parameter int NUM_LAYERS   = 4,
	parameter int MAX_WIDTH    = 64,
	parameter int MAX_HEIGHT   = 64,
	parameter int TILE_ID_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [MODE_W-1:0]            mode,
	input  logic signed [SEL_W-1:0]      layer_sel,
	input  logic signed [POS_W-1:0]      pos_x,
	input  logic signed [POS_W-1:0]      pos_y,
	input  logic [TV_W-1:0]              tile_value,
	output logic                         done,
	output logic signed [TILE_OUT_W-1:0] tile_out,
	output logic                         is_collision,
	output logic                         rejected,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_idx,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int DIM_W      = $clog2(MAX_DIM + 1);
	localparam int TILE_DEPTH = NUM_LAYERS * MAX_WIDTH * MAX_HEIGHT;
	localparam int TAW        = $clog2(TILE_DEPTH);
	localparam int MD         = 2 ** TILE_ID_BITS;

	logic [NUM_LAYERS-1:0][DIM_W-1:0] layer_w;
	logic [NUM_LAYERS-1:0][DIM_W-1:0] layer_h;
	ram_ctl_t                         tile_ctl;
	logic [TAW-1:0]                   tile_addr;
	logic [TILE_ID_BITS-1:0]          tile_wdata;
	logic [TILE_ID_BITS-1:0]          tile_rdata;
	ram_ctl_t                         mark_ctl;
	logic [TILE_ID_BITS-1:0]          mark_addr;
	logic                             mark_rdata;

	ltms_cfg #(
		.NUM_LAYERS (NUM_LAYERS),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.DIM_W      (DIM_W)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.layer_w  (layer_w),
		.layer_h  (layer_h)
	);

	ltms_seq #(
		.NUM_LAYERS   (NUM_LAYERS),
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.TILE_ID_BITS (TILE_ID_BITS),
		.DIM_W        (DIM_W),
		.TAW          (TAW)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.layer_sel    (layer_sel),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.tile_value   (tile_value),
		.layer_w      (layer_w),
		.layer_h      (layer_h),
		.tile_ctl     (tile_ctl),
		.tile_addr    (tile_addr),
		.tile_wdata   (tile_wdata),
		.tile_rdata   (tile_rdata),
		.mark_ctl     (mark_ctl),
		.mark_addr    (mark_addr),
		.mark_rdata   (mark_rdata),
		.done         (done),
		.tile_out     (tile_out),
		.is_collision (is_collision),
		.rejected     (rejected)
	);

	ltms_ram #(
		.WIDTH (TILE_ID_BITS),
		.DEPTH (TILE_DEPTH)
	) u_tile_ram (
		.clk   (clk),
		.en    (tile_ctl.en),
		.we    (tile_ctl.we),
		.addr  (tile_addr),
		.wdata (tile_wdata),
		.rdata (tile_rdata)
	);

	// marks only ever get set, so the stored word is always one
	ltms_ram #(
		.WIDTH (1),
		.DEPTH (MD)
	) u_mark_ram (
		.clk   (clk),
		.en    (mark_ctl.en),
		.we    (mark_ctl.we),
		.addr  (mark_addr),
		.wdata (1'b1),
		.rdata (mark_rdata)
	);

endmodule
